[rtl/ols_pkg.sv]
// Shared types and constants for the over-temperature lockout supervisor.
`timescale 1ns / 1ps
`default_nettype none

package ols_pkg;

  localparam int TEMP_W = 12;

  // Lockout cause codes.
  localparam logic [1:0] CAUSE_NONE = 2'd0;
  localparam logic [1:0] CAUSE_ONE  = 2'd1;
  localparam logic [1:0] CAUSE_TWO  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_TRIP_ONE = 1'b0;
  localparam logic CFG_TRIP_TWO = 1'b1;

  localparam logic signed [TEMP_W-1:0] TRIP_RESET = 12'sd1360;
  localparam logic [3:0] STREAK_MAX = 4'd15;

  typedef struct packed {
    logic [1:0]               known_sensors;
    logic                     first_valid;
    logic signed [TEMP_W-1:0] first_temp;
    logic                     second_valid;
    logic signed [TEMP_W-1:0] second_temp;
  } ols_request_t;

  typedef struct packed {
    logic [2:0]               startup_count;
    logic                     locked;
    logic [1:0]               trip_source;
    logic [3:0]               fail_streak;
    logic [3:0]               scan_timer;
    logic signed [TEMP_W-1:0] held_one;
    logic signed [TEMP_W-1:0] held_two;
  } ols_state_t;

  typedef struct packed {
    logic                     first_ok;
    logic                     second_ok;
    logic signed [TEMP_W-1:0] first_held;
    logic signed [TEMP_W-1:0] second_held;
    logic                     rescan_due;
    logic                     lockout_active;
    logic [1:0]               lockout_cause;
  } ols_result_t;

endpackage

`default_nettype wire

[rtl/overtemp_lockout_supervisor.sv]
// Top level of the over-temperature lockout supervisor.
//
// Each request on the input channel (in_valid/in_ready) is one measurement
// cycle for two sensors; each produces exactly one result on the output
// channel (out_valid/out_ready), in order.
// A request is captured in an input register, then evaluated against the
// supervisor state by a single level of logic that writes the result
// register; out_valid rises when the request moves from the input register
// into the result register, which can wait while the receiver stalls.
// Throughput is one request per clock; the input register can advance
// whenever the result register is empty or being taken in the same cycle.
// When the receiver stalls, the result register holds its value, the input
// register fills, and in_ready drops until out_ready returns.
// The trip levels are written through cfg_write/cfg_index/cfg_data and
// should only change while no request is in flight.
// Synchronous reset empties both registers, clears all counters, the held
// readings and the lockout, and restores both trip levels to 1360
// (85 degrees in 1/16 degree units). A latched lockout clears only on reset.
`timescale 1ns / 1ps
`default_nettype none

module overtemp_lockout_supervisor #(
  parameter int BLANKING_READS = 5,
  parameter int RESCAN_PERIOD  = 10,
  parameter int FAIL_LIMIT     = 10
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic               cfg_index,
  input  wire logic signed [11:0] cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         known_sensors,
  input  wire logic               first_valid,
  input  wire logic signed [11:0] first_temp,
  input  wire logic               second_valid,
  input  wire logic signed [11:0] second_temp,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    first_ok,
  output logic                    second_ok,
  output logic signed [11:0]      first_held,
  output logic signed [11:0]      second_held,
  output logic                    rescan_due,
  output logic                    lockout_active,
  output logic [1:0]              lockout_cause
);
  import ols_pkg::*;

  logic signed [TEMP_W-1:0] trip_one;
  logic signed [TEMP_W-1:0] trip_two;

  ols_request_t req;
  logic         req_valid;
  ols_state_t   state;
  ols_state_t   state_next;
  ols_result_t  result_next;
  ols_result_t  result;
  logic         advance;

  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      trip_one <= TRIP_RESET;
      trip_two <= TRIP_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_TRIP_ONE) begin
        trip_one <= cfg_data;
      end else begin
        trip_two <= cfg_data;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req.known_sensors <= known_sensors;
      req.first_valid   <= first_valid;
      req.first_temp    <= first_temp;
      req.second_valid  <= second_valid;
      req.second_temp   <= second_temp;
    end
  end

  ols_step #(
    .BLANKING_READS (BLANKING_READS),
    .RESCAN_PERIOD  (RESCAN_PERIOD),
    .FAIL_LIMIT     (FAIL_LIMIT)
  ) u_step (
    .req        (req),
    .state      (state),
    .trip_one   (trip_one),
    .trip_two   (trip_two),
    .state_next (state_next),
    .result     (result_next)
  );

  // Supervisor state advances only when a request moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign first_ok       = result.first_ok;
  assign second_ok      = result.second_ok;
  assign first_held     = result.first_held;
  assign second_held    = result.second_held;
  assign rescan_due     = result.rescan_due;
  assign lockout_active = result.lockout_active;
  assign lockout_cause  = result.lockout_cause;

endmodule

`default_nettype wire

[rtl/ols_step.sv]
// Next-state and result logic for one measurement request.
`timescale 1ns / 1ps
`default_nettype none

module ols_step #(
  parameter int BLANKING_READS = 5,
  parameter int RESCAN_PERIOD  = 10,
  parameter int FAIL_LIMIT     = 10
) (
  input  wire ols_pkg::ols_request_t    req,
  input  wire ols_pkg::ols_state_t      state,
  input  wire logic signed [11:0]       trip_one,
  input  wire logic signed [11:0]       trip_two,
  output ols_pkg::ols_state_t           state_next,
  output ols_pkg::ols_result_t          result
);
  import ols_pkg::*;

  localparam logic [2:0] BLANK_LAST = 3'(BLANKING_READS);
  localparam logic [3:0] PERIOD     = 4'(RESCAN_PERIOD);
  localparam logic [3:0] LIMIT      = 4'(FAIL_LIMIT);

  logic       scan_needed;
  logic [3:0] ticks_inc;
  logic       rescan;
  logic [3:0] streak_mid;
  logic       ok1;
  logic       ok2;

  always_comb begin
    state_next = state;

    // The rescan decision looks at the streak from before this request.
    scan_needed = (req.known_sensors < 2'd2) || (state.fail_streak >= LIMIT);
    ticks_inc   = state.scan_timer + 4'd1;
    rescan      = 1'b0;
    streak_mid  = state.fail_streak;
    if (scan_needed) begin
      state_next.scan_timer = ticks_inc;
      if (ticks_inc >= PERIOD) begin
        state_next.scan_timer = 4'd0;
        streak_mid            = 4'd0;
        rescan                = 1'b1;
      end
    end

    ok1 = req.first_valid && (req.known_sensors != 2'd0);
    ok2 = req.second_valid && req.known_sensors[1];

    if (ok2) begin
      state_next.fail_streak = 4'd0;
    end else if (streak_mid < STREAK_MAX) begin
      state_next.fail_streak = streak_mid + 4'd1;
    end else begin
      state_next.fail_streak = streak_mid;
    end

    if (ok1) begin
      state_next.held_one = req.first_temp;
    end
    if (ok2) begin
      state_next.held_two = req.second_temp;
    end

    // Sensor one has priority; once latched, no further checks run.
    if (state.startup_count < BLANK_LAST) begin
      state_next.startup_count = state.startup_count + 3'd1;
    end else if (!state.locked) begin
      if (ok1 && (req.first_temp >= trip_one)) begin
        state_next.locked      = 1'b1;
        state_next.trip_source = CAUSE_ONE;
      end else if (ok2 && (req.second_temp >= trip_two)) begin
        state_next.locked      = 1'b1;
        state_next.trip_source = CAUSE_TWO;
      end
    end

    result.first_ok       = ok1;
    result.second_ok      = ok2;
    result.first_held     = state_next.held_one;
    result.second_held    = state_next.held_two;
    result.rescan_due     = rescan;
    result.lockout_active = state_next.locked;
    result.lockout_cause  = state_next.trip_source;
  end

endmodule

`default_nettype wire
